// ----- hdl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants of the bounded deque
// Holds the sizes, operation and status codes, beat payloads and the control
// structs passed between the sequencer and the cell row.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;
    localparam int VALUE_W    = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_REAR   = 3'd3;
    localparam logic [2:0] OP_DUMP       = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]                 operation;
        logic signed [VALUE_W-1:0]  item_value;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  data_value;
        logic [1:0]                 status;
        logic                       last;
    } out_item_t;

    typedef enum logic [0:0] {
        FSM_IDLE,
        FSM_DUMP
    } fsm_t;

    // Shift and load commands broadcast to every cell
    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
    } cell_cmd_t;

    // What the output register captures on this edge
    typedef struct packed {
        logic       fire;
        logic       from_head;
        logic       from_mux;
        logic [1:0] status;
        logic       last;
    } resp_ctl_t;

    // Sign-extend or cut a stored entry to the result width
    function automatic logic signed [VALUE_W-1:0] widen(input logic [DATA_WIDTH-1:0] v);
        logic signed [DATA_WIDTH-1:0] s;
        s = $signed(v);
        return VALUE_W'(s);
    endfunction

endpackage

// ----- hdl/bdq_cell.sv -----
// ----------------------------------------------------------------------------
// bdq_cell: one slot of the deque row
// Takes the left neighbor on a front push, the right neighbor on a front pop,
// and the pushed value when it is the tail slot of a rear push.
// ----------------------------------------------------------------------------
module bdq_cell
    import bdq_pkg::*;
(
    input  logic                  clk,
    input  cell_cmd_t             cmd,
    input  logic                  tail_sel,
    input  logic [DATA_WIDTH-1:0] push_data,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.push_front)
        begin
            data_next = left_data;
        end
        else if (cmd.pop_front)
        begin
            data_next = right_data;
        end
        else if (cmd.push_rear && tail_sel)
        begin
            data_next = push_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- hdl/bdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bdq_ctrl: operation sequencer of the deque
// Decodes each accepted beat, keeps the fill count, and walks the row
// one entry per cycle during a dump.
// ----------------------------------------------------------------------------
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [2:0]       operation,
    output logic             busy,
    output cell_cmd_t        cmd,
    output logic [CNT_W-1:0] count,
    output logic [IDX_W-1:0] rd_idx,
    output resp_ctl_t        resp
);

    fsm_t             state_reg;
    fsm_t             state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [IDX_W-1:0] walk_reg;
    logic [IDX_W-1:0] walk_next;
    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic [CNT_W-1:0] cnt_dec;
    logic             walk_end;

    assign accept   = start && (state_reg == FSM_IDLE);
    assign is_full  = (cnt_reg == CNT_W'(DEPTH));
    assign is_empty = (cnt_reg == '0);
    assign cnt_dec  = cnt_reg - 1'b1;
    assign walk_end = ((CNT_W'(walk_reg) + 1'b1) == cnt_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (accept && (operation == OP_DUMP) && !is_empty)
                begin
                    state_next = FSM_DUMP;
                end
            end
            FSM_DUMP:
            begin
                if (walk_end)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Outputs, count and walk pointer
    always_comb
    begin
        cmd       = '0;
        resp      = '0;
        rd_idx    = cnt_dec[IDX_W-1:0];
        cnt_next  = cnt_reg;
        walk_next = walk_reg;
        busy      = 1'b0;
        case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    resp.last = 1'b1;
                    case (operation)
                        OP_PUSH_FRONT, OP_PUSH_REAR:
                        begin
                            resp.fire = 1'b1;
                            if (is_full)
                            begin
                                resp.status = ST_FULL;
                            end
                            else
                            begin
                                resp.status    = ST_OK;
                                cmd.push_front = (operation == OP_PUSH_FRONT);
                                cmd.push_rear  = (operation == OP_PUSH_REAR);
                                cnt_next       = cnt_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            resp.fire = 1'b1;
                            if (is_empty)
                            begin
                                resp.status = ST_EMPTY;
                            end
                            else
                            begin
                                resp.status    = ST_OK;
                                resp.from_head = 1'b1;
                                cmd.pop_front  = 1'b1;
                                cnt_next       = cnt_dec;
                            end
                        end
                        OP_POP_REAR:
                        begin
                            resp.fire = 1'b1;
                            if (is_empty)
                            begin
                                resp.status = ST_EMPTY;
                            end
                            else
                            begin
                                resp.status   = ST_OK;
                                resp.from_mux = 1'b1;
                                cnt_next      = cnt_dec;
                            end
                        end
                        OP_DUMP:
                        begin
                            // a non-empty dump emits nothing here; the walk follows
                            walk_next = '0;
                            if (is_empty)
                            begin
                                resp.fire   = 1'b1;
                                resp.status = ST_EMPTY;
                            end
                        end
                        default:
                        begin
                            resp.last = 1'b0;
                        end
                    endcase
                end
            end
            FSM_DUMP:
            begin
                busy          = 1'b1;
                rd_idx        = walk_reg;
                resp.fire     = 1'b1;
                resp.from_mux = 1'b1;
                resp.status   = ST_OK;
                resp.last     = walk_end;
                walk_next     = walk_reg + 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            cnt_reg   <= '0;
            walk_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            walk_reg  <= walk_next;
        end
    end

    assign count = cnt_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_DUMP) |-> (CNT_W'(walk_reg) < cnt_reg))
        else $error("dump walk beyond occupied entries");

    a_dump_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_DUMP) |=> $stable(cnt_reg))
        else $error("count changed during dump");

    a_dump_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_DUMP) |-> (cmd == '0))
        else $error("cell row written during dump");

endmodule

// ----- hdl/bounded_deque.sv -----
// ----------------------------------------------------------------------------
// bounded_deque: double-ended queue of signed values on a row of cells
// Pushes and pops at either end, plus a front-to-rear dump of all entries.
// ----------------------------------------------------------------------------
// Usage:
//   Drive item (operation, item_value) with start. A beat is taken at a
//   rising edge where start is high and busy is low.
//   Each result beat shows on result for exactly one cycle with result_valid
//   high; the receiver cannot hold it off, so sample it in that cycle.
//   Results are registered at the taking edge; dump beats come from the walk.
//   Pushes and pops leave busy low, so a new beat may follow in every cycle.
//   A dump raises busy while it walks and emits one beat per entry, front
//   first, last set on the rear entry; the row stays still while the dump
//   walks. An empty dump, a pop on an empty queue and a push on a full
//   queue each give one beat with an error status.
//   Codes 5 to 7 are ignored and give no beat.
//   Storage: DEPTH cells in a chain, front in cell 0. A front push shifts the
//   row right, a front pop shifts it left, a rear push loads the cell at the
//   fill count. Rear pops and the dump read through one DEPTH-to-1 mux.
//   Reset: asynchronous, clears the fill count and the sequencer; cell
//   contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module bounded_deque
    import bdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  item,
    output logic      busy,
    output out_item_t result,
    output logic      result_valid
);

    cell_cmd_t             cmd;
    resp_ctl_t             resp;
    logic [CNT_W-1:0]      count;
    logic [IDX_W-1:0]      rd_idx;
    logic [DATA_WIDTH-1:0] push_data;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] mux_data;
    logic                  result_valid_reg;
    out_item_t             result_reg;
    out_item_t             result_next;

    // Keep the low DATA_WIDTH bits of the pushed value
    assign push_data = DATA_WIDTH'($unsigned(item.item_value));

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (item.operation),
        .busy      (busy),
        .cmd       (cmd),
        .count     (count),
        .rd_idx    (rd_idx),
        .resp      (resp)
    );

    // Chain of cells: cell 0 is the front, its left input is the pushed value
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_in;
        logic [DATA_WIDTH-1:0] right_in;

        if (i == 0)
        begin : g_head
            assign left_in = push_data;
        end
        else
        begin : g_body
            assign left_in = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_in = cell_data[i];
        end
        else
        begin : g_inner
            assign right_in = cell_data[i+1];
        end

        bdq_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .tail_sel   (count == CNT_W'(i)),
            .push_data  (push_data),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i])
        );
    end

    // Rear pops and dump beats read here
    assign mux_data = cell_data[rd_idx];

    // Form the next result beat; zero data unless a value is returned
    always_comb
    begin
        result_next            = result_reg;
        if (resp.fire)
        begin
            result_next.status = resp.status;
            result_next.last   = resp.last;
            if (resp.from_head)
            begin
                result_next.data_value = widen(cell_data[0]);
            end
            else if (resp.from_mux)
            begin
                result_next.data_value = widen(mux_data);
            end
            else
            begin
                result_next.data_value = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= resp.fire;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule
